@@ rtl/assert_macros.svh @@
// Assertion macros used by the allocator RTL.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/bba_pkg.sv @@
// Shared types, constants and helper functions for the buddy allocator.
// No dependencies; used by bba_node_ram and buddy_block_allocator.
package bba_pkg;

	localparam int LOG2_MAX_UNITS = 10;
	localparam int NODE_AW = LOG2_MAX_UNITS + 1;
	localparam int NODE_COUNT = 2 << LOG2_MAX_UNITS;

	typedef logic [NODE_AW-1:0] node_idx_t;
	typedef logic [3:0] node_val_t;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_CLAIM = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_NOT_TAKEN = 2'd2
	} status_t;

	localparam logic REG_POOL_ORDER = 1'b0;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ROOT_RD,
		S_ROOT_CHK,
		S_DESC_RD,
		S_DESC_CHK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_TAKE,
		S_UP_RD,
		S_UP_CHK,
		S_FIN_RD,
		S_FIN_CHK
	} state_t;

	// Smallest s with 2^s >= u, for u in 1..2047.
	function automatic logic [3:0] ceil_log2(input logic [10:0] u);
		logic [3:0] res;
		res = 4'd11;
		for (int s = 11; s >= 0; s--) begin
			if ((12'd1 << s) >= {1'b0, u})
				res = 4'(s);
		end
		return res;
	endfunction

	// Index of the highest set bit, 0 for zero.
	function automatic logic [3:0] floor_log2(input node_idx_t v);
		logic [3:0] res;
		res = 4'd0;
		for (int i = 0; i < NODE_AW; i++) begin
			if (v[i])
				res = 4'(i);
		end
		return res;
	endfunction

endpackage

@@ rtl/buddy_block_allocator.sv @@
// Binary buddy allocator over 2^pool_order units, tree held in a 2048 x 4 node RAM.
// Each command walks the tree one level at a time, with a read state and a check state
// per level, through one pair of RAM read ports: an allocate descends to its size level
// and climbs up to as many levels again to update ancestors; a claim climbs up to
// pool_order levels to check its path and again to update it; free and query climb up
// to pool_order levels in all. A new beat is taken only after the last result is loaded.
// After reset and after every pool_order write, a clearing pass over all 2048 nodes
// rebuilds the tree; no beat is accepted during it. Depends on bba_pkg, bba_node_ram.
`include "assert_macros.svh"
module buddy_block_allocator import bba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [10:0] units,
	input  logic [9:0]  offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [9:0]  block_offset,
	output logic [10:0] block_units,
	output logic [10:0] largest_free
);

	state_t state_q, state_d;
	logic [3:0] pool_order_q;
	node_idx_t clr_q;
	cmd_t cmd_q;
	logic [3:0] slog_q;
	logic [3:0] lvl_q;
	logic [9:0] offset_q;
	node_idx_t idx_q;
	node_idx_t sidx_q;
	logic first_q;
	node_val_t cur_q;
	node_val_t take_val_q;
	logic [9:0] boff_q;
	logic [10:0] bunits_q;
	status_t status_q;
	logic out_valid_q;
	logic [1:0] out_status_q;
	logic [9:0] out_boff_q;
	logic [10:0] out_bunits_q;
	logic [10:0] out_largest_q;

	logic cfg_wr, in_acc, out_load;
	logic [3:0] ord;
	node_idx_t pool, leaf;
	logic [3:0] slog_in, lvl_c, clr_d;
	logic oob, pow_ok;
	node_val_t rda, rdb, clr_val, sp1, mval, upd_val;
	logic root_fail, go_left, scan_ok, scan_found, up_write;
	node_idx_t child, par_idx;
	logic [3:0] lvl_dn, nl;
	logic ram_we;
	node_idx_t ram_wa, ram_ra, ram_rb;
	node_val_t ram_wd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POOL_ORDER);
	assign prdata = (paddr[2] == REG_POOL_ORDER) ? {28'd0, pool_order_q} : 32'd0;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;

	assign ord = (pool_order_q > 4'(LOG2_MAX_UNITS)) ? 4'(LOG2_MAX_UNITS) : pool_order_q;
	assign pool = node_idx_t'(1) << ord;
	assign leaf = node_idx_t'(offset) + pool;
	assign oob = ({1'b0, offset} >= pool);
	assign slog_in = ceil_log2(units);
	assign lvl_c = (slog_in < ord) ? slog_in : ord;
	assign pow_ok = ((11'd1 << lvl_c) == units);

	assign clr_d = floor_log2(clr_q);
	assign clr_val = (clr_q == '0 || clr_d > ord) ? 4'd0 : 4'(ord - clr_d + 4'd1);

	assign root_fail = (rda == 4'd0) || ((rda - 4'd1) < slog_q);
	assign sp1 = slog_q + 4'd1;
	assign go_left = (rdb < sp1) || ((rda >= sp1) && (rda <= rdb));
	assign child = {idx_q[NODE_AW-2:0], !go_left};
	assign lvl_dn = lvl_q - 4'd1;

	assign scan_ok = first_q ? (rda == lvl_q + 4'd1) : (rda != 4'd0);
	assign scan_found = (rda == 4'd0);

	assign par_idx = idx_q >> 1;
	assign mval = (cur_q > rda) ? cur_q : rda;
	assign nl = lvl_q + 4'd1;
	assign upd_val = (cmd_q == CMD_FREE && cur_q == nl && rda == nl) ? nl + 4'd1 : mval;
	assign up_write = (cmd_q == CMD_FREE) || (mval != rdb);

	assign out_load = (state_q == S_FIN_CHK) && (!out_valid_q || !out_stall);

	always_comb begin
		ram_we = 1'b0;
		ram_wa = idx_q;
		ram_wd = take_val_q;
		ram_ra = node_idx_t'(1);
		ram_rb = node_idx_t'(1);
		unique case (state_q)
			S_CLEAR: begin
				ram_we = !cfg_wr;
				ram_wa = clr_q;
				ram_wd = clr_val;
			end
			S_DESC_RD: begin
				ram_ra = {idx_q[NODE_AW-2:0], 1'b0};
				ram_rb = {idx_q[NODE_AW-2:0], 1'b1};
			end
			S_SCAN_RD: ram_ra = sidx_q;
			S_TAKE: ram_we = 1'b1;
			S_UP_RD: begin
				ram_ra = idx_q ^ node_idx_t'(1);
				ram_rb = par_idx;
			end
			S_UP_CHK: begin
				ram_we = up_write;
				ram_wa = par_idx;
				ram_wd = upd_val;
			end
			S_IDLE, S_ROOT_RD, S_ROOT_CHK, S_DESC_CHK, S_SCAN_CHK, S_FIN_RD,
			S_FIN_CHK: ;
			default: ;
		endcase
	end

	bba_node_ram u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_wa),
		.wdata   (ram_wd),
		.raddr_a (ram_ra),
		.raddr_b (ram_rb),
		.rdata_a (rda),
		.rdata_b (rdb)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == node_idx_t'(NODE_COUNT - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (in_acc) begin
					unique case (cmd_t'(cmd))
						CMD_ALLOC: state_d = (units == '0) ? S_FIN_RD : S_ROOT_RD;
						CMD_CLAIM: state_d = (oob || units == '0 || !pow_ok) ?
							S_FIN_RD : S_SCAN_RD;
						CMD_FREE, CMD_QUERY: state_d = oob ? S_FIN_RD : S_SCAN_RD;
						default: state_d = S_FIN_RD;
					endcase
				end
			end
			S_ROOT_RD: state_d = S_ROOT_CHK;
			S_ROOT_CHK: begin
				if (root_fail)
					state_d = S_FIN_RD;
				else
					state_d = (ord > slog_q) ? S_DESC_RD : S_TAKE;
			end
			S_DESC_RD: state_d = S_DESC_CHK;
			S_DESC_CHK: state_d = (lvl_dn > slog_q) ? S_DESC_RD : S_TAKE;
			S_SCAN_RD: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (cmd_q == CMD_CLAIM) begin
					if (!scan_ok)
						state_d = S_FIN_RD;
					else
						state_d = (sidx_q == node_idx_t'(1)) ? S_TAKE : S_SCAN_RD;
				end else if (scan_found) begin
					state_d = (cmd_q == CMD_FREE) ? S_TAKE : S_FIN_RD;
				end else begin
					state_d = (sidx_q <= node_idx_t'(1)) ? S_FIN_RD : S_SCAN_RD;
				end
			end
			S_TAKE: state_d = (idx_q > node_idx_t'(1)) ? S_UP_RD : S_FIN_RD;
			S_UP_RD: state_d = S_UP_CHK;
			S_UP_CHK: begin
				if (!up_write || par_idx <= node_idx_t'(1))
					state_d = S_FIN_RD;
				else
					state_d = S_UP_RD;
			end
			S_FIN_RD: state_d = S_FIN_CHK;
			S_FIN_CHK: if (out_load) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
		if (cfg_wr)
			state_d = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pool_order_q <= 4'd10;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				pool_order_q <= pwdata[3:0];
				clr_q <= '0;
			end else if (state_q == S_CLEAR) begin
				clr_q <= clr_q + node_idx_t'(1);
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= cmd_t'(cmd);
				slog_q <= slog_in;
				offset_q <= offset;
				first_q <= 1'b1;
				boff_q <= '0;
				bunits_q <= '0;
				take_val_q <= 4'd0;
				status_q <= ST_OK;
				case (cmd_t'(cmd))
					CMD_ALLOC: if (units == '0) status_q <= ST_NO_SPACE;
					CMD_CLAIM: begin
						lvl_q <= lvl_c;
						sidx_q <= leaf >> lvl_c;
						idx_q <= leaf >> lvl_c;
						boff_q <= (offset >> lvl_c) << lvl_c;
						if (oob || units == '0 || !pow_ok)
							status_q <= ST_NO_SPACE;
					end
					default: begin
						lvl_q <= 4'd0;
						sidx_q <= leaf;
						if (oob)
							status_q <= ST_NOT_TAKEN;
					end
				endcase
			end
			S_ROOT_CHK: begin
				idx_q <= node_idx_t'(1);
				lvl_q <= ord;
				if (root_fail)
					status_q <= ST_NO_SPACE;
			end
			S_DESC_CHK: begin
				idx_q <= child;
				lvl_q <= lvl_dn;
				if (!go_left)
					boff_q <= boff_q + (10'd1 << lvl_dn);
			end
			S_SCAN_CHK: begin
				if (cmd_q == CMD_CLAIM) begin
					first_q <= 1'b0;
					sidx_q <= sidx_q >> 1;
					if (!scan_ok)
						status_q <= ST_NO_SPACE;
				end else if (scan_found) begin
					idx_q <= sidx_q;
					take_val_q <= lvl_q + 4'd1;
					boff_q <= (offset_q >> lvl_q) << lvl_q;
					bunits_q <= 11'd1 << lvl_q;
				end else begin
					sidx_q <= sidx_q >> 1;
					lvl_q <= lvl_q + 4'd1;
					if (sidx_q <= node_idx_t'(1))
						status_q <= ST_NOT_TAKEN;
				end
			end
			S_TAKE: begin
				cur_q <= take_val_q;
				bunits_q <= 11'd1 << lvl_q;
			end
			S_UP_CHK: begin
				cur_q <= upd_val;
				idx_q <= par_idx;
				lvl_q <= nl;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_boff_q <= (status_q == ST_OK) ? boff_q : 10'd0;
			out_bunits_q <= (status_q == ST_OK) ? bunits_q : 11'd0;
			out_largest_q <= (rda == 4'd0) ? 11'd0 : (11'd1 << (rda - 4'd1));
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign block_offset = out_boff_q;
	assign block_units = out_bunits_q;
	assign largest_free = out_largest_q;

	`BBA_ASSERT(a_fail_zero, !out_valid_q || out_status_q == ST_OK || (out_boff_q == '0 && out_bunits_q == '0), "failed result carries a block")
	`BBA_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "accepted a beat without going busy")
	`BBA_ASSERT_NEXT(a_cfg_clears, cfg_wr, state_q == S_CLEAR, "pool_order write did not start clearing pass")

endmodule

@@ rtl/bba_node_ram.sv @@
// Node level memory: one write port and two registered read ports.
// Depends on bba_pkg for the node index and value types.
module bba_node_ram import bba_pkg::*; (
	input  logic      clk,
	input  logic      we,
	input  node_idx_t waddr,
	input  node_val_t wdata,
	input  node_idx_t raddr_a,
	input  node_idx_t raddr_b,
	output node_val_t rdata_a,
	output node_val_t rdata_b
);

	node_val_t mem [NODE_COUNT];
	node_val_t rda_q;
	node_val_t rdb_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rda_q <= mem[raddr_a];
		rdb_q <= mem[raddr_b];
	end

	assign rdata_a = rda_q;
	assign rdata_b = rdb_q;

endmodule

@@ tb/tb_buddy_block_allocator.sv @@
// Self-checking testbench for buddy_block_allocator: directed table, then random commands.
// Results are checked against typed rows or an in-bench tree model; needs bba_pkg and RTL.
`timescale 1ns / 100ps
module tb_buddy_block_allocator import bba_pkg::*; ();

	typedef struct packed {
		status_t     st;
		logic [9:0]  off;
		logic [10:0] un;
		logic [10:0] lf;
	} alloc_res_t;

	typedef struct {
		cmd_t       c;
		int         u;
		int         o;
		bit         typed;
		alloc_res_t r;
	} dir_row_t;

	localparam int LIMIT = 20000;
	localparam int TAIL = 100;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  cmd = '0;
	logic [10:0] units = '0;
	logic [9:0]  offset = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  status;
	logic [9:0]  block_offset;
	logic [10:0] block_units;
	logic [10:0] largest_free;

	buddy_block_allocator u_top (.*);

	always #10 clk = ~clk;

	// Model of the allocator tree.
	int unsigned tree_lv[NODE_COUNT];
	int unsigned pool_cfg;
	alloc_res_t  pending_res[$];
	int          live_offs[$];
	int          mismatches = 0;
	int          beats_in = 0, beats_out = 0, idle_cycles = 0;
	int          snd_idle_pct = 0, rcv_idle_pct = 0;
	bit          hold_go = 0, hold_seen = 0;
	int          hold_left = 0;

	function automatic int unsigned eff_order();
		return (pool_cfg > LOG2_MAX_UNITS) ? LOG2_MAX_UNITS : pool_cfg;
	endfunction

	function automatic void rebuild_tree();
		int unsigned ord;
		ord = eff_order();
		foreach (tree_lv[i]) tree_lv[i] = 0;
		for (int d = 0; d <= ord; d++)
			for (int i = (1 << d); i < (2 << d); i++)
				tree_lv[i] = ord - d + 1;
	endfunction

	function automatic void fix_ancestors(int unsigned idx);
		int unsigned l, r, m;
		while (idx > 1) begin
			idx >>= 1;
			l = tree_lv[2*idx];
			r = tree_lv[2*idx+1];
			m = (l > r) ? l : r;
			if (m == tree_lv[idx])
				break;
			tree_lv[idx] = m;
		end
	endfunction

	function automatic alloc_res_t apply_cmd(cmd_t c, int unsigned u, int unsigned o);
		alloc_res_t res;
		int unsigned ord, pool, slog, idx, lvl, root, l, r, a, v;
		bit ok, found;
		ord = eff_order();
		pool = 1 << ord;
		res = '{ST_OK, 0, 0, 0};
		if (c == CMD_ALLOC) begin
			slog = 0;
			idx = 1;
			lvl = ord;
			root = tree_lv[1];
			while (slog < 12 && (1 << slog) < u) slog++;
			if (u == 0 || root == 0 || root - 1 < slog) begin
				res.st = ST_NO_SPACE;
			end else begin
				// Prefer the tighter subtree that still fits.
				while (lvl > slog) begin
					l = tree_lv[2*idx];
					r = tree_lv[2*idx+1];
					if (r < slog + 1 || (l >= slog + 1 && l <= r))
						idx = 2 * idx;
					else
						idx = 2 * idx + 1;
					lvl--;
				end
				tree_lv[idx] = 0;
				res.off = 10'((idx - (1 << (ord - lvl))) << lvl);
				res.un = 11'(1 << lvl);
				fix_ancestors(idx);
			end
		end else if (c == CMD_CLAIM) begin
			if (o >= pool || u == 0) begin
				res.st = ST_NO_SPACE;
			end else begin
				lvl = 0;
				idx = o + pool;
				while ((1 << lvl) < u && lvl < ord) begin
					lvl++;
					idx >>= 1;
				end
				ok = ((1 << lvl) == u) && tree_lv[idx] == lvl + 1;
				for (a = idx >> 1; ok && a >= 1; a >>= 1)
					if (tree_lv[a] == 0)
						ok = 0;
				if (!ok) begin
					res.st = ST_NO_SPACE;
				end else begin
					tree_lv[idx] = 0;
					res.off = 10'((o >> lvl) << lvl);
					res.un = 11'(1 << lvl);
					fix_ancestors(idx);
				end
			end
		end else begin
			lvl = 0;
			found = 0;
			if (o < pool) begin
				idx = o + pool;
				forever begin
					if (tree_lv[idx] == 0) begin
						found = 1;
						break;
					end
					if (idx <= 1)
						break;
					idx >>= 1;
					lvl++;
				end
			end
			if (!found) begin
				res.st = ST_NOT_TAKEN;
			end else begin
				res.off = 10'((o >> lvl) << lvl);
				res.un = 11'(1 << lvl);
				if (c == CMD_FREE) begin
					tree_lv[idx] = lvl + 1;
					// Merge with the buddy wherever both halves are wholly free.
					while (idx > 1) begin
						idx >>= 1;
						lvl++;
						l = tree_lv[2*idx];
						r = tree_lv[2*idx+1];
						if (l == lvl && r == lvl)
							tree_lv[idx] = lvl + 1;
						else
							tree_lv[idx] = (l > r) ? l : r;
					end
				end
			end
		end
		v = tree_lv[1];
		res.lf = v ? 11'(1 << (v - 1)) : 11'd0;
		return res;
	endfunction

	// Sender: the beat stays up until it is taken, then the next call reuses or drops it.
	task automatic send_beat(cmd_t c, int unsigned u, int unsigned o, bit typed,
			alloc_res_t want);
		alloc_res_t got;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		units <= u[10:0];
		offset <= o[9:0];
		do @(posedge clk); while (in_stall);
		beats_in++;
		got = apply_cmd(c, u & 2047, o & 1023);
		if (got.st == ST_OK && (c == CMD_ALLOC || c == CMD_CLAIM))
			live_offs.push_back(int'(got.off));
		pending_res.push_back(typed ? want : got);
	endtask

	task automatic drop_valid();
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic write_pool_order(int unsigned v);
		drop_valid();
		wait (pending_res.size() == 0);
		repeat (TAIL) @(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= {REG_POOL_ORDER, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		pool_cfg = v & 15;
		rebuild_tree();
		live_offs.delete();
	endtask

	task automatic run_random(int n);
		int unsigned ord, pool, r, k, u, o, i;
		cmd_t c;
		repeat (n) begin
			ord = eff_order();
			pool = 1 << ord;
			r = $urandom_range(99);
			o = $urandom_range(pool - 1);
			if (r < 35) begin
				c = CMD_ALLOC;
				u = (r < 3) ? $urandom_range(2047) : $urandom_range(1 << $urandom_range(ord), 1);
			end else if (r < 55) begin
				c = CMD_CLAIM;
				k = $urandom_range(ord);
				u = 1 << k;
				if (r < 45)
					o = o & ~(u - 1);
				if (r == 54)
					u = $urandom_range(2047);
			end else if (r < 85) begin
				c = CMD_FREE;
				if (live_offs.size() > 0) begin
					i = $urandom_range(live_offs.size() - 1);
					o = live_offs[i];
					live_offs.delete(i);
				end
			end else if (r < 95) begin
				c = CMD_QUERY;
				if (live_offs.size() > 0 && r < 90)
					o = live_offs[$urandom_range(live_offs.size() - 1)];
			end else begin
				c = cmd_t'($urandom_range(3));
				u = $urandom_range(2047);
				o = $urandom_range(1023);
			end
			send_beat(c, u, o, 0, '0);
		end
		drop_valid();
	endtask

	// Receiver stall, with a long hold-off on request.
	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= 400;
			out_stall <= 1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		alloc_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (pending_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: st=%0d off=%0d units=%0d lf=%0d",
						status, block_offset, block_units, largest_free);
			end else begin
				want = pending_res.pop_front();
				if (status !== want.st || block_offset !== want.off ||
						block_units !== want.un || largest_free !== want.lf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d off=%0d units=%0d lf=%0d, got st=%0d off=%0d units=%0d lf=%0d",
							want.st, want.off, want.un, want.lf,
							status, block_offset, block_units, largest_free);
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("timeout after %0d quiet cycles, %0d beats still owed",
				idle_cycles, pending_res.size());
			$display("tb_buddy_block_allocator: FAIL");
			$finish;
		end
	end

	dir_row_t dir_tab[] = '{
		'{CMD_QUERY, 0, 0, 1, '{ST_NOT_TAKEN, 0, 0, 1024}},
		'{CMD_ALLOC, 0, 0, 1, '{ST_NO_SPACE, 0, 0, 1024}},
		'{CMD_ALLOC, 2047, 0, 1, '{ST_NO_SPACE, 0, 0, 1024}},
		'{CMD_CLAIM, 3, 0, 1, '{ST_NO_SPACE, 0, 0, 1024}},
		'{CMD_CLAIM, 0, 0, 1, '{ST_NO_SPACE, 0, 0, 1024}},
		'{CMD_CLAIM, 1024, 0, 1, '{ST_OK, 0, 1024, 0}},
		'{CMD_ALLOC, 1, 0, 1, '{ST_NO_SPACE, 0, 0, 0}},
		'{CMD_QUERY, 0, 1023, 1, '{ST_OK, 0, 1024, 0}},
		'{CMD_FREE, 0, 5, 1, '{ST_OK, 0, 1024, 1024}},
		'{CMD_FREE, 0, 5, 1, '{ST_NOT_TAKEN, 0, 0, 1024}},
		'{CMD_ALLOC, 1, 0, 0, '0},
		'{CMD_ALLOC, 3, 0, 0, '0},
		'{CMD_CLAIM, 4, 6, 0, '0},
		'{CMD_CLAIM, 1, 0, 0, '0},
		'{CMD_ALLOC, 1024, 0, 0, '0},
		'{CMD_QUERY, 0, 6, 0, '0},
		'{CMD_FREE, 0, 6, 0, '0},
		'{CMD_ALLOC, 512, 0, 0, '0},
		'{CMD_ALLOC, 512, 0, 0, '0},
		'{CMD_FREE, 0, 512, 0, '0},
		'{CMD_CLAIM, 1, 1023, 0, '0},
		'{CMD_QUERY, 0, 1023, 0, '0},
		'{CMD_FREE, 0, 1023, 0, '0},
		'{CMD_FREE, 0, 0, 0, '0}
	};

	initial begin
		pool_cfg = 10;
		rebuild_tree();
		repeat (3) @(posedge clk);
		arst_n <= 1;

		foreach (dir_tab[i])
			send_beat(dir_tab[i].c, dir_tab[i].u, dir_tab[i].o, dir_tab[i].typed,
				dir_tab[i].r);

		// One-unit pool, then an out-of-range order that saturates.
		write_pool_order(0);
		send_beat(CMD_CLAIM, 1, 1, 0, '0);
		send_beat(CMD_CLAIM, 1, 0, 0, '0);
		send_beat(CMD_ALLOC, 1, 0, 0, '0);
		send_beat(CMD_FREE, 0, 0, 0, '0);
		write_pool_order(15);
		send_beat(CMD_ALLOC, 1024, 0, 0, '0);
		send_beat(CMD_QUERY, 0, 1023, 0, '0);

		snd_idle_pct = 33;
		rcv_idle_pct = 46;
		run_random(270);

		write_pool_order(5);
		snd_idle_pct = 46;
		rcv_idle_pct = 33;
		run_random(270);

		write_pool_order(10);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_go = 1;
		run_random(260);

		wait (pending_res.size() == 0);
		repeat (TAIL) @(posedge clk);
		$display("Ran %0d commands over pool orders 0, 5, 10 and a saturated write;", beats_in);
		$display("%0d results checked, %0d mismatches.", beats_out, mismatches);
		if (mismatches == 0 && pending_res.size() == 0)
			$display("tb_buddy_block_allocator: PASS");
		else
			$display("tb_buddy_block_allocator: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_node_ram.sv
rtl/buddy_block_allocator.sv
tb/tb_buddy_block_allocator.sv
